FILE: rtl/sfc_pkg.sv
// Package with types and constants shared by the sphere frustum cull unit.
package sfc_pkg;

	localparam int MaxEntities = 1024;
	localparam int MaxPlanes   = 8;
	localparam int EntW        = 10;
	localparam int WordBits    = 32;
	localparam int KW          = 5;

	localparam logic [1:0] OP_LOAD_PLANE  = 2'd0;
	localparam logic [1:0] OP_LOAD_SPHERE = 2'd1;
	localparam logic [1:0] OP_WORD        = 2'd2;
	localparam logic [1:0] OP_CLEAR       = 2'd3;

	localparam logic [1:0] REG_PLANE_COUNT  = 2'd0;
	localparam logic [1:0] REG_DRAW_ENABLED = 2'd1;

	typedef struct packed {
		logic signed [18:0] a;
		logic signed [18:0] b;
		logic signed [18:0] c;
		logic signed [31:0] d;
	} plane_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [30:0]        r;
	} sphere_t;

	// Token handed from one plane cell to the next.
	typedef struct packed {
		logic           vld;
		logic           rej;
		logic [EntW-1:0] ent;
		sphere_t        sph;
	} tok_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_WALK,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/sfc_cell.sv
// One plane cell: holds one clipping plane and tests the passing sphere against it.
module sfc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ld,
	input  sfc_pkg::plane_t ld_plane,
	input  logic            active,
	input  sfc_pkg::tok_t   tok_in,
	output sfc_pkg::tok_t   tok_out
);
	import sfc_pkg::*;

	plane_t             plane_q;
	tok_t               tok_s1;
	logic signed [63:0] pa_s1, pb_s1, pc_s1, dr_s1;
	logic signed [63:0] sum;

	always_ff @(posedge clk) begin
		if (ld) begin
			plane_q <= ld_plane;
		end
	end

	// Stage one: the three products and the scaled offset.
	always_ff @(posedge clk) begin
		pa_s1 <= 64'(plane_q.a * tok_in.sph.x);
		pb_s1 <= 64'(plane_q.b * tok_in.sph.y);
		pc_s1 <= 64'(plane_q.c * tok_in.sph.z);
		dr_s1 <= (64'(plane_q.d) + $signed({33'd0, tok_in.sph.r})) <<< 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1 <= tok_in;
		end
	end

	// Stage two: sum and sign test, folded into the reject flag.
	assign sum = pa_s1 + pb_s1 + pc_s1 + dr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else begin
			tok_out.vld <= tok_s1.vld;
			tok_out.ent <= tok_s1.ent;
			tok_out.sph <= tok_s1.sph;
			tok_out.rej <= tok_s1.rej | (active & (sum <= 64'sd0));
		end
	end

endmodule

FILE: rtl/sphere_frustum_cull_bitmask_unit.sv
// Top level of the sphere frustum cull unit: control, stores and the plane cell chain.
// A load or clear word is taken and the next word can follow at once. A membership
// word walks its 32 bits at one bit per cycle, each candidate reading the sphere memory
// and passing through a chain of eight plane cells; once the chain is flushed the walk
// ends. Marked results leave one per cycle while not stalled as they reach the end of
// the chain, the completion word comes after them, and the next input word is taken in
// the cycle after the completion word leaves. With drawing disabled, or a word number
// past the last entity, the completion word is offered in the cycle after the input.
// After reset the visible marks are all clear; a clear word clears them.
module sphere_frustum_cull_bitmask_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [9:0]  index,
	input  logic signed [18:0] plane_a,
	input  logic signed [18:0] plane_b,
	input  logic signed [18:0] plane_c,
	input  logic signed [31:0] plane_d,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [30:0] radius,
	input  logic [31:0] cell_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [9:0]  entity_number,
	output logic        marked,
	output logic        last
);
	import sfc_pkg::*;

	localparam int Lat = 2 * MaxPlanes;
	localparam int QD  = 32;

	// Configuration registers.
	logic [3:0] plane_count_q;
	logic       draw_enabled_q;
	logic       wr;
	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q  <= 4'd0;
			draw_enabled_q <= 1'b1;
		end else if (wr) begin
			case (paddr[2])
				REG_PLANE_COUNT[0]:  plane_count_q  <= pwdata[3:0];
				REG_DRAW_ENABLED[0]: draw_enabled_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PLANE_COUNT[0]: prdata = {28'd0, plane_count_q};
			default:            prdata = {31'd0, draw_enabled_q};
		endcase
	end

	// Control state.
	state_t            state_q, state_d;
	logic [KW:0]       k_q;
	logic [31:0]       bits_q;
	logic [EntW-KW-1:0] wbase_q;
	logic [5:0]        drain_q;
	logic              acc;

	assign acc = in_valid & ~in_stall;

	// Result queue for marked entities; the completion word follows it from the DONE state.
	logic [EntW-1:0] q_ent [QD];
	logic [5:0]      q_wp_q, q_rp_q, q_cnt;
	logic            q_push, q_pop;
	assign q_cnt = q_wp_q - q_rp_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && opcode == OP_WORD)
					state_d = (draw_enabled_q && index[EntW-1:KW] == '0) ? ST_FETCH : ST_DONE;
			end
			ST_FETCH: if (k_q[KW]) state_d = ST_WALK;
			ST_WALK:  if (drain_q == 6'(Lat + 1)) state_d = ST_DONE;
			ST_DONE:  if (q_cnt == 6'd0 && q_pop) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				k_q     <= '0;
				drain_q <= '0;
			end else if (state_q == ST_FETCH) begin
				k_q <= k_q + 1'b1;
			end else if (state_q == ST_WALK) begin
				drain_q <= drain_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			bits_q  <= cell_bits;
			wbase_q <= index[EntW-KW-1:0];
		end
	end

	// Plane loads.
	plane_t ld_plane;
	assign ld_plane = '{a: plane_a, b: plane_b, c: plane_c, d: plane_d};

	// Sphere memory, registered read.
	sphere_t sph_mem [MaxEntities];
	sphere_t rd_s1;
	logic [EntW-1:0] ent_s1;
	logic            cand_s1;
	logic [EntW-1:0] cur_ent;
	logic            cur_bit;
	assign cur_ent = {wbase_q, k_q[KW-1:0]};
	assign cur_bit = bits_q[5'd31 - k_q[KW-1:0]];

	always_ff @(posedge clk) begin
		if (acc && opcode == OP_LOAD_SPHERE) begin
			sph_mem[index] <= '{x: pos_x, y: pos_y, z: pos_z, r: radius};
		end
		rd_s1  <= sph_mem[cur_ent];
		ent_s1 <= cur_ent;
	end

	// Visible marks, one 32-bit row per membership word. The row of the current word is
	// copied into a working register when the word is taken and written back when the
	// walk ends; a row not written since the last clear reads as all clear.
	logic [WordBits-1:0]             vis_mem [MaxEntities/WordBits];
	logic [MaxEntities/WordBits-1:0] row_ok_q;
	logic [WordBits-1:0]             row_q, row_d;
	logic                            row_wb;
	logic                            cand;
	tok_t                            chain [MaxPlanes+1];
	tok_t                            tail;

	assign tail   = chain[MaxPlanes];
	assign row_wb = (state_q == ST_WALK) & (state_d == ST_DONE);
	assign cand   = (state_q == ST_FETCH) & ~k_q[KW] & cur_bit & ~row_q[k_q[KW-1:0]];

	// A candidate is marked at selection; a rejected one has its mark removed at the end.
	always_comb begin
		row_d = row_q;
		if (cand) row_d[k_q[KW-1:0]] = 1'b1;
		if (tail.vld && tail.rej) row_d[tail.ent[KW-1:0]] = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (acc && opcode == OP_WORD) begin
			row_q <= row_ok_q[index[EntW-KW-1:0]] ? vis_mem[index[EntW-KW-1:0]] : '0;
		end else begin
			row_q <= row_d;
		end
	end

	always_ff @(posedge clk) begin
		if (row_wb) begin
			vis_mem[wbase_q] <= row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
		end else if (acc && opcode == OP_CLEAR) begin
			row_ok_q <= '0;
		end else if (row_wb) begin
			row_ok_q[wbase_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_s1 <= 1'b0;
		end else begin
			cand_s1 <= cand;
		end
	end

	assign chain[0] = '{vld: cand_s1, rej: 1'b0, ent: ent_s1, sph: rd_s1};

	genvar g;
	generate
		for (g = 0; g < MaxPlanes; g++) begin : g_cell
			sfc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ld       (acc && opcode == OP_LOAD_PLANE && index == EntW'(g)),
				.ld_plane (ld_plane),
				.active   (plane_count_q > 4'(g)),
				.tok_in   (chain[g]),
				.tok_out  (chain[g+1])
			);
		end
	endgenerate

	// Queue writes: entities that pass every active plane.
	assign q_push = tail.vld & ~tail.rej;
	assign q_pop  = out_valid & ~out_stall;

	always_ff @(posedge clk) begin
		if (q_push) begin
			q_ent[q_wp_q[4:0]] <= tail.ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wp_q <= '0;
			q_rp_q <= '0;
		end else begin
			if (q_push) q_wp_q <= q_wp_q + 1'b1;
			if (q_pop && q_cnt != 6'd0) q_rp_q <= q_rp_q + 1'b1;
		end
	end

	// Queued marks go first; with the queue empty in DONE the completion word is shown.
	assign out_valid     = (q_cnt != 6'd0) | (state_q == ST_DONE);
	assign entity_number = (q_cnt != 6'd0) ? q_ent[q_rp_q[4:0]] : '0;
	assign marked        = (q_cnt != 6'd0);
	assign last          = (q_cnt == 6'd0);

`ifndef SYNTHESIS
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("input taken while busy");
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt <= 6'd32) else $error("result queue overrun");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (q_cnt == 6'd0)) else $error("results left at idle");
`endif

endmodule

FILE: tb/sv/sfc_checker.sv
// Checker for the sphere frustum cull unit: predicts marked entities and compares results.
module sfc_checker
	import sfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [9:0]  index,
	input  logic signed [18:0] plane_a,
	input  logic signed [18:0] plane_b,
	input  logic signed [18:0] plane_c,
	input  logic signed [31:0] plane_d,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [30:0] radius,
	input  logic [31:0] cell_bits,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [9:0]  entity_number,
	input  logic        marked,
	input  logic        last,
	output int          fail_count,
	output int          pending_results,
	output int          marks_seen,
	output int          words_seen
);

	typedef struct packed {
		logic [9:0] ent;
		logic       mk;
		logic       lst;
	} cull_result_t;

	plane_t       planes [MaxPlanes];
	sphere_t      spheres [MaxEntities];
	logic         visible [MaxEntities];
	logic [3:0]   active_planes;
	logic         drawing;
	cull_result_t expected_results [$];

	assign pending_results = expected_results.size();

	// Exact plane test: true when some active plane rejects the sphere.
	function automatic logic sphere_rejected(int e);
		int n;
		logic signed [63:0] s;
		n = (active_planes > MaxPlanes) ? MaxPlanes : active_planes;
		for (int p = 0; p < n; p++) begin
			s = 64'(planes[p].a) * 64'(spheres[e].x) + 64'(planes[p].b) * 64'(spheres[e].y)
				+ 64'(planes[p].c) * 64'(spheres[e].z)
				+ ((64'(planes[p].d) + $signed({33'd0, spheres[e].r})) <<< 16);
			if (s <= 0)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// Apply one accepted word to the predicted state.
	task automatic predict_word();
		int e;
		case (opcode)
			OP_LOAD_PLANE: begin
				if (index < MaxPlanes)
					planes[index] = '{plane_a, plane_b, plane_c, plane_d};
			end
			OP_LOAD_SPHERE: spheres[index] = '{pos_x, pos_y, pos_z, radius};
			OP_CLEAR: foreach (visible[i]) visible[i] = 1'b0;
			default: begin
				if (drawing) begin
					for (int k = 0; k < WordBits; k++) begin
						e = index * WordBits + k;
						if (cell_bits[31 - k] && e < MaxEntities && !visible[e]
							&& !sphere_rejected(e)) begin
							visible[e] = 1'b1;
							expected_results.push_back('{e[9:0], 1'b1, 1'b0});
						end
					end
				end
				expected_results.push_back('{10'd0, 1'b0, 1'b1});
				words_seen++;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		cull_result_t want;
		if (!arst_n) begin
			active_planes = 4'd0;
			drawing = 1'b1;
			foreach (visible[i]) visible[i] = 1'b0;
			fail_count = 0;
			marks_seen = 0;
			words_seen = 0;
			expected_results.delete();
		end else begin
			// Register writes.
			if (psel && penable && pwrite) begin
				if (paddr[2:2] == REG_PLANE_COUNT[0])
					active_planes = pwdata[3:0];
				else
					drawing = pwdata[0];
			end
			if (in_valid && !in_stall)
				predict_word();
			// Compare each delivered result with the oldest expectation.
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = expected_results.pop_front();
					if (marked) marks_seen++;
					if (entity_number !== want.ent)
						report_mismatch($sformatf("entity_number %0d, expected %0d",
							entity_number, want.ent));
					if (marked !== want.mk)
						report_mismatch($sformatf("marked %b, expected %b", marked, want.mk));
					if (last !== want.lst)
						report_mismatch($sformatf("last %b, expected %b", last, want.lst));
				end
			end
		end
	end

endmodule

FILE: tb/sv/testbench.sv
// Testbench top for the sphere frustum cull unit: stimulus, register writes and verdict.
module testbench;
	import sfc_pkg::*;

	localparam int WatchdogLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_stall;
	logic [1:0] opcode = OP_CLEAR;
	logic [9:0] index = '0;
	logic signed [18:0] plane_a = '0, plane_b = '0, plane_c = '0;
	logic signed [31:0] plane_d = '0, pos_x = '0, pos_y = '0, pos_z = '0;
	logic [30:0] radius = '0;
	logic [31:0] cell_bits = '0;
	logic out_valid, out_stall = 1'b0;
	logic [9:0] entity_number;
	logic marked, last;
	int fail_count, pending_results, marks_seen, words_seen;
	int idle_cycles = 0;
	int stall_left = 0;
	logic loaded [MaxEntities];

	always #1 clk = ~clk;

	sphere_frustum_cull_bitmask_unit dut (.*);

	sfc_checker u_checker (.*);

	// Gap length: mostly short, now and then long, sometimes none.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver stalls at random, in runs that are mostly short and now and then long.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left == 0 && $urandom_range(0, 3) == 0)
				stall_left = gap_len();
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left = stall_left - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles with nothing accepted.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("watchdog expired");
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] reg_id, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {reg_id[0], 2'b00}; pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Present one word and hold it until accepted; valid stays high for a back-to-back word.
	task automatic send_word(logic [1:0] op, logic [9:0] idx, logic [31:0] bits);
		int gap;
		logic [31:0] masked_bits;
		gap = gap_len();
		masked_bits = bits;
		// Words may not read never-loaded spheres; bits past the last entity stay.
		if (op == OP_WORD)
			for (int k = 0; k < 32; k++)
				if (idx * 32 + k < MaxEntities && !loaded[idx * 32 + k])
					masked_bits[31 - k] = 1'b0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		index <= idx;
		plane_a <= 19'($urandom_range(0, 262143));
		plane_b <= 19'($urandom_range(0, 262143));
		plane_c <= 19'($urandom_range(0, 262143));
		plane_d <= $urandom;
		pos_x <= $urandom;
		pos_y <= $urandom;
		pos_z <= $urandom;
		radius <= 31'($urandom);
		cell_bits <= masked_bits;
		if (op == OP_LOAD_SPHERE) loaded[idx] = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results != 0) @(posedge clk);
		repeat (80) @(negedge clk);
	endtask

	// Load all planes with random values, then spheres for the first two words.
	task automatic load_scene();
		for (int p = 0; p < MaxPlanes; p++) send_word(OP_LOAD_PLANE, p[9:0], 0);
		for (int e = 0; e < 64; e++) send_word(OP_LOAD_SPHERE, e[9:0], 0);
	endtask

	initial begin
		foreach (loaded[i]) loaded[i] = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed: drawing with no planes marks everything loaded.
		send_word(OP_LOAD_SPHERE, 10'd1023, 0);
		send_word(OP_LOAD_SPHERE, 10'd0, 0);
		send_word(OP_LOAD_PLANE, 10'd1023, 0);
		send_word(OP_WORD, 10'd0, 32'hFFFF_FFFF);
		send_word(OP_WORD, 10'd0, 32'hFFFF_FFFF);
		send_word(OP_WORD, 10'd31, 32'h0000_0001);
		send_word(OP_WORD, 10'd1023, 32'hFFFF_FFFF);
		send_word(OP_CLEAR, 10'd0, 0);
		send_word(OP_WORD, 10'd31, 32'hFFFF_FFFF);
		drain();
		load_scene();
		drain();

		// Random phases over the register settings, extremes included.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(REG_PLANE_COUNT, 32'd8); write_reg(REG_DRAW_ENABLED, 32'd1); end
				1: write_reg(REG_PLANE_COUNT, 32'd15);
				2: write_reg(REG_DRAW_ENABLED, 32'd0);
				3: begin write_reg(REG_DRAW_ENABLED, 32'd1); write_reg(REG_PLANE_COUNT, 32'd1); end
				4: write_reg(REG_PLANE_COUNT, 32'd0);
				default: write_reg(REG_PLANE_COUNT, 32'($urandom_range(2, 7)));
			endcase
			for (int n = 0; n < 10; n++) begin
				case ($urandom_range(0, 9))
					0: send_word(OP_LOAD_PLANE, 10'($urandom_range(0, 9)), 0);
					1: send_word(OP_LOAD_SPHERE, 10'($urandom_range(0, 1023)), 0);
					2: send_word(OP_CLEAR, 10'($urandom), 0);
					default: send_word(OP_WORD, 10'($urandom_range(0, 1)), $urandom);
				endcase
			end
			send_word(OP_WORD, 10'($urandom), $urandom);
			drain();
		end

		$display("covered %0d membership words and %0d marked entities",
			words_seen, marks_seen);
		$display("register settings swept: plane counts 0, 1, 8, 15 and drawing on and off");
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

FILE: sphere_frustum_cull_bitmask_unit.f
rtl/sfc_pkg.sv
rtl/sfc_cell.sv
rtl/sphere_frustum_cull_bitmask_unit.sv
tb/sv/sfc_checker.sv
tb/sv/testbench.sv
